// ===== design/sfd_pkg.sv =====
// sfd_pkg: shared constants, types and helpers for the sensor frame deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package sfd_pkg;

  localparam int WIN_DEPTH = 15;          // bytes held before the current one
  localparam int ANT_OFS   = WIN_DEPTH - 3; // antenna header position in window
  localparam int GRP_W     = 7;           // payload bits per byte
  localparam int PAYLOAD_W = 112;         // packed result fields

  localparam logic [7:0] HDR_NAV = 8'h68;
  localparam logic [7:0] HDR_ANT = 8'h69;
  localparam logic [7:0] CHK_BIT = 8'h80;

  typedef logic [7:0] rx_byte_t;
  typedef rx_byte_t [WIN_DEPTH-1:0] window_t; // index 0 is the oldest byte

  typedef enum logic {
    KIND_NAV = 1'b0,
    KIND_ANT = 1'b1
  } frame_kind_t;

  // First member lands in the top bits: latitude ends up at bit 0.
  typedef struct packed {
    logic [13:0] antenna_angle;
    logic [13:0] air_pressure;
    logic [13:0] vertical_speed;
    logic [13:0] track_angle;
    logic [27:0] longitude;
    logic [27:0] latitude;
  } payload_t;

  typedef struct packed {
    logic nav_hit;
    logic ant_hit;
  } hit_t;

  function automatic logic [GRP_W-1:0] grp7(input rx_byte_t b);
    return b[GRP_W-1:0];
  endfunction

endpackage : sfd_pkg

`default_nettype wire

// ===== design/sfd_window.sv =====
// sfd_window: 15-byte shift register of the most recent received bytes.
// Depends on sfd_pkg.
`default_nettype none

module sfd_window
  import sfd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     shift_en,
  input  wire rx_byte_t rx_byte,
  output window_t       win
);

  window_t win_r;
  window_t win_nxt;

  always_comb begin
    win_nxt = win_r;
    if (shift_en) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[WIN_DEPTH-1] = rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else begin
      win_r <= win_nxt;
    end
  end

  assign win = win_r;

endmodule : sfd_window

`default_nettype wire

// ===== design/sfd_match.sv =====
// sfd_match: checks both frame types ending at the incoming byte and
// extracts their fields. Pure combinational; depends on sfd_pkg.
`default_nettype none

module sfd_match
  import sfd_pkg::*;
(
  input  wire window_t  win,
  input  wire rx_byte_t rx_byte,
  output hit_t          hit,
  output payload_t      nav_pl,
  output payload_t      ant_pl
);

  rx_byte_t nav_x;
  rx_byte_t ant_x;

  always_comb begin
    nav_x = '0;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      nav_x = nav_x ^ win[i];
    end
    ant_x = win[ANT_OFS] ^ win[ANT_OFS+1] ^ win[ANT_OFS+2];

    // check byte equals XOR | 0x80, and a bare 0x80 never passes
    hit.nav_hit = (win[0] == HDR_NAV) && ((nav_x | CHK_BIT) == rx_byte) &&
                  (rx_byte != CHK_BIT);
    hit.ant_hit = (win[ANT_OFS] == HDR_ANT) && ((ant_x | CHK_BIT) == rx_byte) &&
                  (rx_byte != CHK_BIT);

    // groups are least significant first
    nav_pl                = '0;
    nav_pl.latitude       = {grp7(win[4]), grp7(win[3]), grp7(win[2]), grp7(win[1])};
    nav_pl.longitude      = {grp7(win[8]), grp7(win[7]), grp7(win[6]), grp7(win[5])};
    nav_pl.track_angle    = {grp7(win[10]), grp7(win[9])};
    nav_pl.vertical_speed = {grp7(win[12]), grp7(win[11])};
    nav_pl.air_pressure   = {grp7(win[14]), grp7(win[13])};

    ant_pl               = '0;
    ant_pl.antenna_angle = {grp7(win[ANT_OFS+2]), grp7(win[ANT_OFS+1])};
  end

endmodule : sfd_match

`default_nettype wire

// ===== design/sfd_queue.sv =====
// sfd_queue: holds the up-to-two results of one byte and feeds them to the
// output register in order, navigation first. Depends on sfd_pkg.
`default_nettype none

module sfd_queue
  import sfd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     load,
  input  wire hit_t     hit,
  input  wire payload_t nav_pl,
  input  wire payload_t ant_pl,
  output logic          load_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output frame_kind_t   out_kind,
  output logic          out_last,
  output payload_t      out_pl
);

  logic        pend_nav_r, pend_nav_nxt;
  logic        pend_ant_r, pend_ant_nxt;
  payload_t    nav_pl_r;
  payload_t    ant_pl_r;
  logic        out_valid_r, out_valid_nxt;
  frame_kind_t out_kind_r;
  logic        out_last_r;
  payload_t    out_pl_r;

  logic out_free;
  logic pend_any;
  logic pend_both;
  logic take;

  assign out_free  = !out_valid_r || out_ready;
  assign pend_any  = pend_nav_r || pend_ant_r;
  assign pend_both = pend_nav_r && pend_ant_r;
  assign take      = out_free && pend_any;

  // room for a new byte once the pending slot empties this cycle
  assign load_ready = !pend_any || (take && !pend_both);

  always_comb begin
    pend_nav_nxt = pend_nav_r && !(take && pend_nav_r);
    pend_ant_nxt = pend_ant_r && !(take && !pend_nav_r);
    if (load) begin
      pend_nav_nxt = hit.nav_hit;
      pend_ant_nxt = hit.ant_hit;
    end

    out_valid_nxt = out_valid_r && !out_ready;
    if (take) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_nav_r  <= 1'b0;
      pend_ant_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_nav_r  <= pend_nav_nxt;
      pend_ant_r  <= pend_ant_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      nav_pl_r <= nav_pl;
      ant_pl_r <= ant_pl;
    end
    if (take) begin
      out_kind_r <= pend_nav_r ? KIND_NAV : KIND_ANT;
      out_last_r <= !pend_both;
      out_pl_r   <= pend_nav_r ? nav_pl_r : ant_pl_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_last  = out_last_r;
  assign out_pl    = out_pl_r;

endmodule : sfd_queue

`default_nettype wire

// ===== design/sensor_frame_deframer.sv =====
// sensor_frame_deframer: top level of the serial sensor frame deframer.
// Instantiates sfd_window, sfd_match and sfd_queue; depends on sfd_pkg.
`default_nettype none

// Byte-stream deframer for a sensor link. Every input beat carries one
// received byte; the block keeps the last 15 bytes and, on each new byte,
// looks for a 16-byte navigation frame (header 0x68) and a 4-byte antenna
// frame (header 0x69) that end at that byte. A frame passes when the XOR of
// its bytes before the check byte, ORed with 0x80, equals the check byte and
// the check byte is not 0x80. Each passing frame gives one output beat;
// when both pass on the same byte the navigation beat comes first and only
// the second beat has tlast set. Throughput is one byte per clock while the
// output is not stalled: the frame check is done in the accept cycle and
// lands in a pending register, which drains into the output register. A
// byte that completes both frames needs two output beats, so in_tready drops
// behind it until the navigation beat has left the pending register.
// After reset the window holds zeros, which never match a header.

module sensor_frame_deframer
  import sfd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input stream
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [PAYLOAD_W-1:0]      out_tdata,  // [27:0] latitude, [55:28] longitude,
                                                // [69:56] track_angle,
                                                // [83:70] vertical_speed,
                                                // [97:84] air_pressure,
                                                // [111:98] antenna_angle
  output logic                      out_tlast,  // last_result
  output logic                      out_tuser   // [0] frame_kind
);

  window_t     win;
  hit_t        hit;
  payload_t    nav_pl;
  payload_t    ant_pl;
  payload_t    out_pl;
  frame_kind_t out_kind;
  logic        in_beat;

  assign in_beat = in_tvalid && in_tready;

  // byte history, shifted on every accepted beat
  sfd_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (in_beat),
    .rx_byte  (in_tdata),
    .win      (win)
  );

  // header/check match and field extraction against the pre-shift window
  sfd_match u_match (
    .win     (win),
    .rx_byte (in_tdata),
    .hit     (hit),
    .nav_pl  (nav_pl),
    .ant_pl  (ant_pl)
  );

  // pending results and output register
  sfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_beat),
    .hit        (hit),
    .nav_pl     (nav_pl),
    .ant_pl     (ant_pl),
    .load_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_kind),
    .out_last   (out_tlast),
    .out_pl     (out_pl)
  );

  assign out_tdata = out_pl;
  assign out_tuser = out_kind;

endmodule : sensor_frame_deframer

`default_nettype wire
